[sv/csvp_pkg.sv]
// ----------------------------------------------------------------------------
// csvp_pkg
// types and constants shared by the codebook slot victim policy block
// ----------------------------------------------------------------------------
package csvp_pkg;

	localparam int unsigned MAX_SLOTS_DEF = 256;
	localparam int unsigned DMG_W = 40;
	localparam logic [DMG_W-1:0] DMG_MAX = '1;

	typedef enum logic [2:0] {
		CMD_BEGIN_FRAME = 3'd0,
		CMD_ADD_DAMAGE  = 3'd1,
		CMD_PICK        = 3'd2,
		CMD_INSTALL     = 3'd3,
		CMD_MARK_USED   = 3'd4,
		CMD_RELEASE     = 3'd5,
		CMD_PALETTE     = 3'd6,
		CMD_NOP         = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		CLS_STALE   = 2'd0,
		CLS_CURRENT = 2'd1,
		CLS_LATER   = 2'd2,
		CLS_NONE    = 2'd3
	} cls_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  entry_index;
		logic [15:0] frame_number;
		logic [31:0] near_dist;
		logic [31:0] far_dist;
		logic        epoch_ahead;
	} req_t;

	typedef struct packed {
		logic [7:0] victim_index;
		logic [1:0] victim_class;
	} res_t;

	// one slot record as held in memory
	typedef struct packed {
		logic [31:0]      epoch;
		logic [DMG_W-1:0] damage;
		logic [15:0]      use_score;
		logic [15:0]      last_use;
		logic             taken;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,      // single-entry read issued
		ST_WB,      // single-entry write back
		ST_SCAN,    // scan pass running (address issue)
		ST_DRAIN,   // last scan read returns
		ST_EVAL,    // pass result settled, decide
		ST_MARK,    // mark picked slot taken
		ST_DONE
	} state_t;

endpackage

[sv/csvp_slot_mem.sv]
// ----------------------------------------------------------------------------
// csvp_slot_mem
// slot record memory, one write and one registered read port
// ----------------------------------------------------------------------------
module csvp_slot_mem import csvp_pkg::*; #(
	parameter int unsigned DEPTH = MAX_SLOTS_DEF,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  slot_t         wdata,
	input  logic [AW-1:0] raddr,
	output slot_t         rdata
);

	slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/csvp_ctrl.sv]
// ----------------------------------------------------------------------------
// csvp_ctrl
// command sequencer: read-modify-write, sweeps and the pick scans
// ----------------------------------------------------------------------------
module csvp_ctrl import csvp_pkg::*; #(
	parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int unsigned AW = $clog2(MAX_SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  req_t          req,
	input  logic          cfg_we,
	input  logic [8:0]    cfg_wdata,
	output logic          busy,
	output logic          done,
	output res_t          result,
	output logic          mark_rd,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output slot_t         mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  slot_t         mem_rdata
);

	localparam int unsigned CW = AW + 1;
	localparam int unsigned LIM = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
	localparam logic [8:0] LIM9 = 9'(LIM);

	state_t state_q, state_d;
	req_t   req_q;
	logic [8:0]  entries_q;
	logic [31:0] pal_q;
	logic [15:0] frame_q;
	logic        init_q;      // clearing pass after reset
	logic [CW-1:0] cnt_q;     // scan/sweep address
	logic [AW-1:0] rd_addr_s1;
	logic          rd_vld_s1;
	cls_t          pass_q;
	logic          sweep_q;   // begin_frame or clearing pass
	logic          have_q;
	logic [AW-1:0] best_q;
	logic [DMG_W-1:0] bd_q;
	logic [15:0]   bu_q, ba_q;
	res_t          res_q;
	logic          done_q;

	logic [8:0] n_act;
	assign n_act = (entries_q > LIM9) ? LIM9 : entries_q;

	logic in_rng;
	assign in_rng = {1'b0, req_q.entry_index} < n_act;

	logic [CW-1:0] scan_end;
	assign scan_end = sweep_q ? CW'(LIM) : CW'(n_act);

	logic [31:0] diff;
	assign diff = req_q.far_dist - req_q.near_dist;

	// candidate evaluation on the returned record
	logic [15:0] age;
	logic        cand, better, take;
	always_comb begin
		age = frame_q - mem_rdata.last_use;
		unique case (pass_q)
			CLS_STALE:   cand = !mem_rdata.taken && (mem_rdata.epoch < pal_q);
			CLS_CURRENT: cand = !mem_rdata.taken && (mem_rdata.epoch == pal_q);
			default:     cand = !mem_rdata.taken;
		endcase
		better = !have_q || mem_rdata.damage < bd_q ||
			(mem_rdata.damage == bd_q && (mem_rdata.use_score < bu_q ||
			(mem_rdata.use_score == bu_q && age > ba_q)));
		// stale pass keeps the lowest index, the others the best record
		take = rd_vld_s1 && !sweep_q && cand &&
			((pass_q == CLS_STALE) ? !have_q : better);
	end

	logic last_issue;
	assign last_issue = (cnt_q + CW'(1)) >= scan_end;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd_t'(req.command))
						CMD_BEGIN_FRAME: state_d = ST_SCAN;
						CMD_PICK:        state_d = (n_act == 9'd0) ? ST_DONE : ST_SCAN;
						CMD_ADD_DAMAGE, CMD_INSTALL, CMD_MARK_USED, CMD_RELEASE:
							state_d = ST_RD;
						default:         state_d = ST_DONE;
					endcase
				end
			end
			ST_RD:   state_d = ST_WB;
			ST_WB:   state_d = ST_DONE;
			ST_SCAN: state_d = last_issue ? ST_DRAIN : ST_SCAN;
			ST_DRAIN: begin
				if (sweep_q) begin
					state_d = init_q ? ST_IDLE : ST_DONE;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (have_q) begin
					state_d = ST_MARK;
				end else if (pass_q == CLS_LATER) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_MARK: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory drive
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(req_q.entry_index);
		mem_wdata = mem_rdata;
		mem_raddr = AW'(req_q.entry_index);
		mark_rd   = 1'b0;
		unique case (state_q)
			ST_SCAN: mem_raddr = cnt_q[AW-1:0];
			ST_WB: begin
				unique case (cmd_t'(req_q.command))
					CMD_ADD_DAMAGE: begin
						mem_we = in_rng && (req_q.far_dist > req_q.near_dist);
						if ({8'd0, diff} > DMG_MAX - mem_rdata.damage) begin
							mem_wdata.damage = DMG_MAX;
						end else begin
							mem_wdata.damage = mem_rdata.damage + DMG_W'(diff);
						end
					end
					CMD_INSTALL: begin
						mem_we              = in_rng;
						mem_wdata.epoch     = pal_q + 32'(req_q.epoch_ahead);
						mem_wdata.use_score = 16'd1;
						mem_wdata.last_use  = req_q.frame_number;
						mem_wdata.taken     = 1'b1;
					end
					CMD_MARK_USED: begin
						mem_we = in_rng;
						if (mem_rdata.use_score != 16'hFFFF) begin
							mem_wdata.use_score = mem_rdata.use_score + 16'd1;
						end
						mem_wdata.last_use = req_q.frame_number;
					end
					CMD_RELEASE: begin
						mem_we          = in_rng;
						mem_wdata.taken = 1'b0;
					end
					default: ;
				endcase
			end
			ST_MARK: begin
				mem_raddr = best_q;
				mark_rd   = 1'b1;
			end
			default: ;
		endcase
		// each sweep write lands in the cycle after its read is issued
		if (sweep_q && rd_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = rd_addr_s1;
			if (init_q) begin
				mem_wdata = '0;
			end else begin
				mem_wdata.use_score = mem_rdata.use_score >> 1;
				mem_wdata.damage    = '0;
				mem_wdata.taken     = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_SCAN;
			init_q             <= 1'b1;
			sweep_q            <= 1'b1;
			cnt_q              <= '0;
			rd_addr_s1         <= '0;
			rd_vld_s1          <= 1'b0;
			pass_q             <= CLS_STALE;
			have_q             <= 1'b0;
			best_q             <= '0;
			bd_q               <= '0;
			bu_q               <= '0;
			ba_q               <= '0;
			req_q              <= '0;
			entries_q          <= 9'd256;
			pal_q              <= '0;
			frame_q            <= '0;
			res_q.victim_index <= '0;
			res_q.victim_class <= CLS_NONE;
			done_q             <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= (state_q == ST_DONE);
			rd_vld_s1  <= (state_q == ST_SCAN);
			rd_addr_s1 <= cnt_q[AW-1:0];
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
			if (take) begin
				have_q <= 1'b1;
				best_q <= rd_addr_s1;
				bd_q   <= mem_rdata.damage;
				bu_q   <= mem_rdata.use_score;
				ba_q   <= age;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q   <= req;
						cnt_q   <= '0;
						pass_q  <= CLS_STALE;
						have_q  <= 1'b0;
						sweep_q <= (cmd_t'(req.command) == CMD_BEGIN_FRAME);
						if (cmd_t'(req.command) == CMD_PALETTE) begin
							pal_q <= pal_q + 32'd1;
						end
						if (cmd_t'(req.command) == CMD_BEGIN_FRAME) begin
							frame_q <= req.frame_number;
						end
						res_q.victim_index <= '0;
						res_q.victim_class <= CLS_NONE;
					end
				end
				ST_SCAN: cnt_q <= cnt_q + CW'(1);
				ST_DRAIN: begin
					if (sweep_q) begin
						init_q <= 1'b0;
					end
				end
				ST_EVAL: begin
					if (have_q) begin
						res_q.victim_index <= 8'(best_q);
						res_q.victim_class <= pass_q;
					end else if (pass_q != CLS_LATER) begin
						pass_q <= (pass_q == CLS_STALE) ? CLS_CURRENT : CLS_LATER;
						cnt_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

[sv/csvp_mark_mux.sv]
// ----------------------------------------------------------------------------
// csvp_mark_mux
// merges the pick taken-mark write into the sequencer write port
// ----------------------------------------------------------------------------
module csvp_mark_mux import csvp_pkg::*; #(
	parameter int unsigned AW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mark_rd,
	input  logic [AW-1:0] mark_addr,
	input  logic          c_we,
	input  logic [AW-1:0] c_waddr,
	input  slot_t         c_wdata,
	input  slot_t         rdata,
	output logic          we,
	output logic [AW-1:0] waddr,
	output slot_t         wdata
);

	logic          pend_q;
	logic [AW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= mark_rd;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= mark_addr;
	end

	always_comb begin
		we    = c_we;
		waddr = c_waddr;
		wdata = c_wdata;
		if (pend_q) begin
			we          = 1'b1;
			waddr       = addr_q;
			wdata       = rdata;
			wdata.taken = 1'b1;
		end
	end

endmodule

[sv/codebook_slot_victim_policy.sv]
// ----------------------------------------------------------------------------
// codebook_slot_victim_policy
// replacement slot picker for a codebook, slot records in one memory
// ----------------------------------------------------------------------------
// add_damage/install/mark_used/release: read, write back, done; palette_change,
// unused command or pick with no active slot: straight to done; begin_frame sweeps
// min(MAX_SLOTS, 256) slots; pick: stale, current, later passes over n active slots
// one request at a time; busy high while it runs; next start taken when done pulses
// after reset busy stays high while the memory is cleared
// the receiver cannot stall: done is high one cycle, result held until next start
module codebook_slot_victim_policy import csvp_pkg::*; #(
	parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  req_t       req,
	output logic       busy,
	output logic       done,
	output res_t       result,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(MAX_SLOTS);

	logic          c_we, m_we, mark_rd;
	logic [AW-1:0] c_waddr, m_waddr, raddr;
	slot_t         c_wdata, m_wdata, rdata;

	csvp_ctrl #(.MAX_SLOTS(MAX_SLOTS), .AW(AW)) u_ctrl (
		.clk, .arst_n, .start, .req, .cfg_we, .cfg_wdata,
		.busy, .done, .result, .mark_rd,
		.mem_we(c_we), .mem_waddr(c_waddr), .mem_wdata(c_wdata),
		.mem_raddr(raddr), .mem_rdata(rdata)
	);

	csvp_mark_mux #(.AW(AW)) u_mark (
		.clk, .arst_n,
		.mark_rd, .mark_addr(raddr),
		.c_we, .c_waddr, .c_wdata, .rdata,
		.we(m_we), .waddr(m_waddr), .wdata(m_wdata)
	);

	csvp_slot_mem #(.DEPTH(MAX_SLOTS), .AW(AW)) u_mem (
		.clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr, .rdata
	);

endmodule

[tb/tb_codebook_slot_victim_policy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_codebook_slot_victim_policy
// drives codebook commands into the victim picker and checks every result
// against a behavioral copy of the slot table, over several slot counts
// ----------------------------------------------------------------------------
module tb_codebook_slot_victim_policy;
	import csvp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic       clk;
	logic       arst_n;
	logic       start;
	req_t       req;
	logic       busy;
	logic       done;
	res_t       result;
	logic       cfg_we;
	logic [8:0] cfg_wdata;

	codebook_slot_victim_policy uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// behavioral slot table
	logic [31:0] m_epoch [256];
	logic [39:0] m_damage [256];
	logic [15:0] m_use [256];
	logic [15:0] m_last [256];
	logic        m_taken [256];
	logic [31:0] m_palette;
	logic [15:0] m_frame;
	logic [8:0]  m_slots;

	res_t victim_q[$];
	int   errors;
	int   n_sent;
	int   n_picks;
	int   idle_pct;
	int   stall_cnt = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic bit slot_better(input int v, input int b);
		logic [15:0] av, ab;
		av = m_frame - m_last[v];
		ab = m_frame - m_last[b];
		if (m_damage[v] != m_damage[b]) return m_damage[v] < m_damage[b];
		if (m_use[v] != m_use[b]) return m_use[v] < m_use[b];
		return av > ab;
	endfunction

	function automatic res_t apply_request(input req_t r);
		res_t o;
		int n, best;
		bit have;
		logic [32:0] add;
		logic [40:0] sum;
		n = (m_slots > 9'd256) ? 256 : int'(m_slots);
		o.victim_index = 0;
		o.victim_class = CLS_NONE;
		case (cmd_t'(r.command))
			CMD_BEGIN_FRAME: begin
				for (int v = 0; v < 256; v++) begin
					m_use[v] = m_use[v] >> 1;
					m_damage[v] = 0;
					m_taken[v] = 0;
				end
				m_frame = r.frame_number;
			end
			CMD_ADD_DAMAGE: begin
				if (r.entry_index < n && r.far_dist > r.near_dist) begin
					add = 33'(r.far_dist) - 33'(r.near_dist);
					sum = 41'(m_damage[r.entry_index]) + 41'(add);
					m_damage[r.entry_index] = sum[40] ? DMG_MAX : sum[39:0];
				end
			end
			CMD_PICK: begin
				have = 0;
				best = 0;
				for (int v = 0; v < n && !have; v++)
					if (!m_taken[v] && m_epoch[v] < m_palette) begin
						have = 1; best = v; o.victim_class = CLS_STALE;
					end
				if (!have) begin
					for (int v = 0; v < n; v++)
						if (!m_taken[v] && m_epoch[v] == m_palette)
							if (!have || slot_better(v, best)) begin
								have = 1; best = v; o.victim_class = CLS_CURRENT;
							end
				end
				if (!have) begin
					for (int v = 0; v < n; v++)
						if (!m_taken[v])
							if (!have || slot_better(v, best)) begin
								have = 1; best = v; o.victim_class = CLS_LATER;
							end
				end
				if (have) begin
					m_taken[best] = 1;
					o.victim_index = 8'(best);
				end
			end
			CMD_INSTALL: begin
				if (r.entry_index < n) begin
					m_epoch[r.entry_index] = m_palette + 32'(r.epoch_ahead);
					m_use[r.entry_index] = 16'd1;
					m_last[r.entry_index] = r.frame_number;
					m_taken[r.entry_index] = 1;
				end
			end
			CMD_MARK_USED: begin
				if (r.entry_index < n) begin
					if (m_use[r.entry_index] != 16'hFFFF)
						m_use[r.entry_index] = m_use[r.entry_index] + 16'd1;
					m_last[r.entry_index] = r.frame_number;
				end
			end
			CMD_RELEASE: if (r.entry_index < n) m_taken[r.entry_index] = 0;
			CMD_PALETTE: m_palette = m_palette + 32'd1;
			default: ;
		endcase
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (victim_q.size() == 0) begin
				report_mismatch("unexpected result", int'(result), 0);
			end else begin
				if (result.victim_index !== victim_q[0].victim_index)
					report_mismatch("victim_index", int'(result.victim_index),
						int'(victim_q[0].victim_index));
				if (result.victim_class !== victim_q[0].victim_class)
					report_mismatch("victim_class", int'(result.victim_class),
						int'(victim_q[0].victim_class));
				void'(victim_q.pop_front());
			end
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("*** FAILED ***");
			$finish;
		end
	end

	// called at a falling edge; busy is stable there until the next rising edge
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		while (busy) @(negedge clk);
		req <= r;
		start <= 1;
		victim_q.push_back(apply_request(r));
		n_sent++;
		if (r.command == CMD_PICK) n_picks++;
		@(negedge clk);
		start <= 0;
	endtask

	task automatic drain;
		while (victim_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_slots(input logic [8:0] val);
		drain();
		cfg_we <= 1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		m_slots = val;
	endtask

	function automatic req_t mk(input cmd_t c, input int idx);
		req_t r;
		r.command = c;
		r.entry_index = 8'(idx);
		r.frame_number = 16'($urandom);
		r.near_dist = $urandom;
		r.far_dist = $urandom;
		r.epoch_ahead = 1'($urandom);
		return r;
	endfunction

	task automatic test_directed;
		req_t r;
		idle_pct = 0;
		send_request(mk(CMD_PICK, 0));
		send_request(mk(CMD_PICK, 0));
		r = mk(CMD_ADD_DAMAGE, 255);
		r.near_dist = 0; r.far_dist = 32'hFFFFFFFF;
		send_request(r);
		r.entry_index = 0; r.near_dist = 32'hFFFFFFFF; r.far_dist = 0;
		send_request(r);
		r.near_dist = 5; r.far_dist = 5;
		send_request(r);
		send_request(mk(CMD_PALETTE, 0));
		send_request(mk(CMD_PICK, 0));
		r = mk(CMD_INSTALL, 3); r.epoch_ahead = 1; r.frame_number = 16'hFFFF;
		send_request(r);
		r = mk(CMD_INSTALL, 4); r.epoch_ahead = 0; r.frame_number = 0;
		send_request(r);
		send_request(mk(CMD_MARK_USED, 4));
		send_request(mk(CMD_RELEASE, 3));
		send_request(mk(CMD_RELEASE, 4));
		send_request(mk(CMD_NOP, 2));
		r = mk(CMD_BEGIN_FRAME, 0); r.frame_number = 16'hFFFF;
		send_request(r);
		send_request(mk(CMD_PICK, 0));
	endtask

	// small table, saturate damage, exhaust every slot
	task automatic test_small_table;
		req_t r;
		write_slots(9'd1);
		send_request(mk(CMD_INSTALL, 1));
		send_request(mk(CMD_PICK, 0));
		send_request(mk(CMD_PICK, 0));
		write_slots(9'd0);
		send_request(mk(CMD_PICK, 0));
		write_slots(9'd4);
		r = mk(CMD_ADD_DAMAGE, 2); r.near_dist = 0; r.far_dist = 32'hFFFFFFFF;
		repeat (260) send_request(r);
		send_request(mk(CMD_PICK, 0));
		send_request(mk(CMD_RELEASE, 0));
	endtask

	task automatic test_random(input int count, input int pct);
		req_t r;
		int roll;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 5) r = mk(CMD_BEGIN_FRAME, 0);
			else if (roll < 30) r = mk(CMD_ADD_DAMAGE, $urandom_range(m_slots + 2));
			else if (roll < 55) r = mk(CMD_PICK, 0);
			else if (roll < 70) r = mk(CMD_INSTALL, $urandom_range(m_slots + 2));
			else if (roll < 82) r = mk(CMD_MARK_USED, $urandom_range(m_slots + 2));
			else if (roll < 92) r = mk(CMD_RELEASE, $urandom_range(m_slots + 2));
			else if (roll < 98) r = mk(CMD_PALETTE, 0);
			else r = mk(cmd_t'($urandom_range(7)), $urandom);
			// narrow distances often so sums collide and ties happen
			if (roll < 20) begin
				r.near_dist = $urandom_range(3);
				r.far_dist = $urandom_range(4);
			end
			send_request(r);
		end
	endtask

	initial begin
		errors = 0; n_sent = 0; n_picks = 0; idle_pct = 0;
		m_palette = 0; m_frame = 0; m_slots = 256;
		for (int v = 0; v < 256; v++) begin
			m_epoch[v] = 0; m_damage[v] = 0; m_use[v] = 0; m_last[v] = 0; m_taken[v] = 0;
		end
		start = 0; req = '0; cfg_we = 0; cfg_wdata = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_small_table();
		write_slots(9'd8);
		test_random(120, 0);
		write_slots(9'd3);
		test_random(120, 57);
		write_slots(9'd256);
		test_random(80, 16);
		write_slots(9'd16);
		test_random(100, 0);
		write_slots(9'd511);
		test_random(80, 57);
		drain();
		$display("sent %0d requests, %0d picks, slot counts 0..511", n_sent, n_picks);
		$display("%0d mismatches", errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
